FILE: hdl/gcf_pkg.sv
// Shared types, constants and fixed-point helpers for the gear contact force unit.
// No dependencies.
`timescale 1ns / 1ps

package gcf_pkg;

  localparam int QW = 32;        // Q16.16 scalar width
  localparam int EW = 21;        // Q8.12 element width
  localparam int PW = EW + QW;   // element by scalar product
  localparam int SW = PW + 2;    // sum of three products
  localparam int XW = 66;        // working width ahead of saturation

  typedef logic signed [QW-1:0] q_t;
  typedef logic signed [EW-1:0] elem_t;
  typedef logic signed [PW-1:0] prod_t;
  typedef logic signed [XW-1:0] wide_t;

  // Register indexes of the configuration port
  typedef enum logic [2:0] {
    REG_SPRING   = 3'd0,
    REG_DAMPING  = 3'd1,
    REG_FRIC_X   = 3'd2,
    REG_FRIC_Y   = 3'd3,
    REG_OFFSET_X = 3'd4,
    REG_OFFSET_Y = 3'd5,
    REG_OFFSET_Z = 3'd6
  } reg_idx_e;

  localparam q_t SPRING_RST  = 32'sd7864320;  // 120.0
  localparam q_t DAMPING_RST = 32'sd0;
  localparam q_t FRIC_RST    = 32'sd52429;    // 0.8
  localparam q_t OFFSET_RST  = 32'sd0;

  localparam wide_t Q_MAX = 66'sd2147483647;
  localparam wide_t Q_MIN = -66'sd2147483648;

  // Clamp to the signed 32-bit range
  function automatic q_t sat_q(input wide_t x);
    q_t r;
    if (x > Q_MAX) begin
      r = 32'sh7FFF_FFFF;
    end else if (x < Q_MIN) begin
      r = 32'sh8000_0000;
    end else begin
      r = x[QW-1:0];
    end
    return r;
  endfunction

  // Pick element j of a packed Q8.12 vector
  function automatic elem_t elem(input logic [3*EW-1:0] w, input int unsigned j);
    elem_t r;
    case (j)
      0:       r = w[EW-1:0];
      1:       r = w[2*EW-1:EW];
      default: r = w[3*EW-1:2*EW];
    endcase
    return r;
  endfunction

  function automatic prod_t mul_eq(input elem_t a, input q_t b);
    return prod_t'(a) * prod_t'(b);
  endfunction

  // Row sum, floor shift by 12, saturate
  function automatic q_t dot_sum(input prod_t a, input prod_t b, input prod_t c);
    logic signed [SW-1:0] s;
    s = SW'(a) + SW'(b) + SW'(c);
    return sat_q(XW'(s >>> 12));
  endfunction

  // Coulomb friction from the mu * Fz product and the sign of the velocity
  function automatic q_t fric(input logic signed [63:0] p, input q_t v);
    wide_t p16;
    q_t    r;
    p16 = XW'(p >>> 16);
    if (v > 0) begin
      r = sat_q(-p16);
    end else if (v < 0) begin
      r = sat_q(p16);
    end else begin
      r = '0;
    end
    return r;
  endfunction

endpackage

FILE: hdl/gear_contact_force_unit.sv
// Gear contact force unit: spring-damper ground contact with Coulomb friction.
// One start transfer per cycle, each reaching done_o through the stages; busy_o stays low.
// Each of the sixteen stages holds one row of multipliers or one sum-and-saturate step.
// Reset clears the stage valid bits and loads the default configuration registers.
// Results cannot be stalled: done_o marks each result for a single cycle.
// Depends on gcf_pkg.
`timescale 1ns / 1ps

module gear_contact_force_unit (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  output logic        busy_o,
  input  logic [62:0] e2b_row0_i,
  input  logic [62:0] e2b_row1_i,
  input  logic [62:0] e2b_row2_i,
  input  logic [62:0] b2e_row0_i,
  input  logic [62:0] b2e_row1_i,
  input  logic [62:0] b2e_row2_i,
  input  logic [62:0] rate_row0_i,
  input  logic [62:0] rate_row1_i,
  input  logic [62:0] rate_row2_i,
  input  logic [62:0] cg_velocity_i,
  input  logic signed [31:0] cg_down_i,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [2:0]  cfg_index_i,
  input  logic [31:0] cfg_data_i,
  output logic        done_o,
  output logic signed [31:0] force_x_o,
  output logic signed [31:0] force_y_o,
  output logic signed [31:0] force_z_o,
  output logic signed [31:0] moment_x_o,
  output logic signed [31:0] moment_y_o,
  output logic signed [31:0] moment_z_o,
  output logic        in_contact_o
);

  localparam int NS = 16;

  typedef struct packed {
    logic [2:0][62:0] e2b;
    logic [2:0][62:0] b2e;
    logic [2:0][62:0] rate;
    logic [62:0]      uvw;
    logic [31:0]      cgd;
    logic [31:0]      depth;
    logic [31:0]      fz;
    logic [2:0][31:0] pe;
    logic [2:0][31:0] pb;
    logic [2:0][31:0] vb;
    logic [2:0][31:0] ve;
    logic [2:0][31:0] fe;
    logic [2:0][31:0] re;
    logic [2:0][31:0] fb;
    logic [2:0][31:0] mb;
    logic             contact;
  } carry_t;

  gcf_pkg::q_t spring_q, damping_q, fric_x_q, fric_y_q;
  gcf_pkg::q_t off_q [3];

  logic   [NS:1] vld_q, vld_d;
  carry_t        car_q [1:NS];
  carry_t        car_d [1:NS];

  gcf_pkg::prod_t pa_q [3][3], pa_d [3][3];  // b2e * offset
  gcf_pkg::prod_t pc_q [3][2], pc_d [3][2];  // e2b * clamped point
  gcf_pkg::prod_t pr_q [3][3], pr_d [3][3];  // rate * body point
  gcf_pkg::prod_t pg_q [3][3], pg_d [3][3];  // b2e * body velocity
  gcf_pkg::prod_t pf_q [3][3], pf_d [3][3];  // e2b * earth force
  gcf_pkg::prod_t pm_q [3][3], pm_d [3][3];  // e2b * earth moment
  logic signed [63:0] ks_q, ks_d, bs_q, bs_d, mx_q, mx_d, my_q, my_d;
  gcf_pkg::wide_t cr_q [4], cr_d [4];       // cross product terms

  assign busy_o      = 1'b0;
  assign cfg_ready_o = 1'b1;

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      spring_q  <= gcf_pkg::SPRING_RST;
      damping_q <= gcf_pkg::DAMPING_RST;
      fric_x_q  <= gcf_pkg::FRIC_RST;
      fric_y_q  <= gcf_pkg::FRIC_RST;
      off_q[0]  <= gcf_pkg::OFFSET_RST;
      off_q[1]  <= gcf_pkg::OFFSET_RST;
      off_q[2]  <= gcf_pkg::OFFSET_RST;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_index_i)
        gcf_pkg::REG_SPRING:   spring_q  <= cfg_data_i;
        gcf_pkg::REG_DAMPING:  damping_q <= cfg_data_i;
        gcf_pkg::REG_FRIC_X:   fric_x_q  <= cfg_data_i;
        gcf_pkg::REG_FRIC_Y:   fric_y_q  <= cfg_data_i;
        gcf_pkg::REG_OFFSET_X: off_q[0]  <= cfg_data_i;
        gcf_pkg::REG_OFFSET_Y: off_q[1]  <= cfg_data_i;
        gcf_pkg::REG_OFFSET_Z: off_q[2]  <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Advance valid bits with the data
  assign vld_d = {vld_q[NS-1:1], start_i && !busy_o};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= vld_d;
    end
  end

  // Stage datapath
  always_comb begin
    gcf_pkg::q_t   pe2, wp;
    gcf_pkg::q_t   np0, np1;
    // capture the transfer and rotate the offset to earth frame
    car_d[1]         = '0;
    car_d[1].e2b     = {e2b_row2_i, e2b_row1_i, e2b_row0_i};
    car_d[1].b2e     = {b2e_row2_i, b2e_row1_i, b2e_row0_i};
    car_d[1].rate    = {rate_row2_i, rate_row1_i, rate_row0_i};
    car_d[1].uvw     = cg_velocity_i;
    car_d[1].cgd     = cg_down_i;
    for (int i = 0; i < 3; i++) begin
      for (int j = 0; j < 3; j++) begin
        pa_d[i][j] = gcf_pkg::mul_eq(gcf_pkg::elem(car_d[1].b2e[i], j), off_q[j]);
      end
    end

    // earth point, depth and contact
    car_d[2] = car_q[1];
    car_d[2].pe[0] = gcf_pkg::dot_sum(pa_q[0][0], pa_q[0][1], pa_q[0][2]);
    car_d[2].pe[1] = gcf_pkg::dot_sum(pa_q[1][0], pa_q[1][1], pa_q[1][2]);
    car_d[2].pe[2] = '0;
    pe2 = gcf_pkg::dot_sum(pa_q[2][0], pa_q[2][1], pa_q[2][2]);
    car_d[2].depth = gcf_pkg::sat_q(gcf_pkg::XW'(pe2) +
                                    gcf_pkg::XW'($signed(car_q[1].cgd)));
    car_d[2].contact = !car_d[2].depth[31];

    // rotate the ground point back to body frame
    car_d[3] = car_q[2];
    for (int i = 0; i < 3; i++) begin
      for (int j = 0; j < 2; j++) begin
        pc_d[i][j] = gcf_pkg::mul_eq(gcf_pkg::elem(car_q[2].e2b[i], j),
                                     $signed(car_q[2].pe[j]));
      end
    end

    car_d[4] = car_q[3];
    for (int i = 0; i < 3; i++) begin
      car_d[4].pb[i] = gcf_pkg::dot_sum(pc_q[i][0], pc_q[i][1], '0);
    end

    // rate cross point
    car_d[5] = car_q[4];
    for (int i = 0; i < 3; i++) begin
      for (int j = 0; j < 3; j++) begin
        pr_d[i][j] = gcf_pkg::mul_eq(gcf_pkg::elem(car_q[4].rate[i], j),
                                     $signed(car_q[4].pb[j]));
      end
    end

    // body velocity of the point
    car_d[6] = car_q[5];
    for (int i = 0; i < 3; i++) begin
      wp = gcf_pkg::dot_sum(pr_q[i][0], pr_q[i][1], pr_q[i][2]);
      car_d[6].vb[i] = gcf_pkg::sat_q(gcf_pkg::XW'(wp) +
        (gcf_pkg::XW'(gcf_pkg::elem(car_q[5].uvw, i)) <<< 4));
    end

    // velocity to earth frame
    car_d[7] = car_q[6];
    for (int i = 0; i < 3; i++) begin
      for (int j = 0; j < 3; j++) begin
        pg_d[i][j] = gcf_pkg::mul_eq(gcf_pkg::elem(car_q[6].b2e[i], j),
                                     $signed(car_q[6].vb[j]));
      end
    end

    car_d[8] = car_q[7];
    for (int i = 0; i < 3; i++) begin
      car_d[8].ve[i] = gcf_pkg::dot_sum(pg_q[i][0], pg_q[i][1], pg_q[i][2]);
    end

    // spring and damper products
    car_d[9] = car_q[8];
    ks_d = 64'(spring_q) * 64'($signed(car_q[8].depth));
    bs_d = 64'(damping_q) * 64'($signed(car_q[8].ve[2]));

    car_d[10] = car_q[9];
    car_d[10].fz = gcf_pkg::sat_q(gcf_pkg::XW'(ks_q >>> 16) +
                                  gcf_pkg::XW'(bs_q >>> 16));

    // friction products and down force
    car_d[11] = car_q[10];
    mx_d = 64'(fric_x_q) * 64'($signed(car_q[10].fz));
    my_d = 64'(fric_y_q) * 64'($signed(car_q[10].fz));
    car_d[11].fe[2] = gcf_pkg::sat_q(-gcf_pkg::XW'($signed(car_q[10].fz)));

    car_d[12] = car_q[11];
    car_d[12].fe[0] = gcf_pkg::fric(mx_q, $signed(car_q[11].ve[0]));
    car_d[12].fe[1] = gcf_pkg::fric(my_q, $signed(car_q[11].ve[1]));

    // force to body frame and moment arm products
    car_d[13] = car_q[12];
    for (int i = 0; i < 3; i++) begin
      for (int j = 0; j < 3; j++) begin
        pf_d[i][j] = gcf_pkg::mul_eq(gcf_pkg::elem(car_q[12].e2b[i], j),
                                     $signed(car_q[12].fe[j]));
      end
    end
    np0 = car_q[12].pe[0];
    np1 = car_q[12].pe[1];
    cr_d[0] = gcf_pkg::XW'($signed(car_q[12].fe[2])) * (-gcf_pkg::XW'(np1));
    cr_d[1] = gcf_pkg::XW'($signed(car_q[12].fe[2])) * (-gcf_pkg::XW'(np0));
    cr_d[2] = gcf_pkg::XW'($signed(car_q[12].fe[0])) * (-gcf_pkg::XW'(np1));
    cr_d[3] = gcf_pkg::XW'($signed(car_q[12].fe[1])) * (-gcf_pkg::XW'(np0));

    car_d[14] = car_q[13];
    for (int i = 0; i < 3; i++) begin
      car_d[14].fb[i] = gcf_pkg::dot_sum(pf_q[i][0], pf_q[i][1], pf_q[i][2]);
    end
    car_d[14].re[0] = gcf_pkg::sat_q(-(cr_q[0] >>> 16));
    car_d[14].re[1] = gcf_pkg::sat_q(cr_q[1] >>> 16);
    car_d[14].re[2] = gcf_pkg::sat_q((cr_q[2] >>> 16) - (cr_q[3] >>> 16));

    // moment to body frame
    car_d[15] = car_q[14];
    for (int i = 0; i < 3; i++) begin
      for (int j = 0; j < 3; j++) begin
        pm_d[i][j] = gcf_pkg::mul_eq(gcf_pkg::elem(car_q[14].e2b[i], j),
                                     $signed(car_q[14].re[j]));
      end
    end

    // final sums; drop everything above ground
    car_d[16] = car_q[15];
    for (int i = 0; i < 3; i++) begin
      car_d[16].mb[i] = gcf_pkg::dot_sum(pm_q[i][0], pm_q[i][1], pm_q[i][2]);
    end
    car_d[16].contact = car_q[15].contact && vld_q[15];
    if (!car_d[16].contact) begin
      car_d[16].fb = '0;
      car_d[16].mb = '0;
    end
  end

  // Stage registers
  always_ff @(posedge clk_i) begin
    for (int s = 1; s <= NS; s++) begin
      car_q[s] <= car_d[s];
    end
    pa_q <= pa_d;
    pc_q <= pc_d;
    pr_q <= pr_d;
    pg_q <= pg_d;
    pf_q <= pf_d;
    pm_q <= pm_d;
    ks_q <= ks_d;
    bs_q <= bs_d;
    mx_q <= mx_d;
    my_q <= my_d;
    cr_q <= cr_d;
  end

  assign done_o       = vld_q[NS];
  assign force_x_o    = car_q[NS].fb[0];
  assign force_y_o    = car_q[NS].fb[1];
  assign force_z_o    = car_q[NS].fb[2];
  assign moment_x_o   = car_q[NS].mb[0];
  assign moment_y_o   = car_q[NS].mb[1];
  assign moment_z_o   = car_q[NS].mb[2];
  assign in_contact_o = car_q[NS].contact;

  // Every transfer yields one result after the pipeline depth
  a_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i && !busy_o |-> ##16 done_o)
    else $error("result missing after transfer");

  // Without contact the result is all zeros
  a_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && !in_contact_o |-> force_x_o == 0 && force_y_o == 0 && force_z_o == 0
      && moment_x_o == 0 && moment_y_o == 0 && moment_z_o == 0)
    else $error("non-zero result above ground");

  // Contact only shows with a result
  a_contact: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !done_o |-> !in_contact_o)
    else $error("contact flag without result");

endmodule

FILE: verif/testbench.sv
// Self-checking testbench for gear_contact_force_unit: directed and random contact points,
// predicted in fixed point and compared field by field. Depends on gcf_pkg and the unit RTL.
`timescale 1ns / 1ps

module testbench;

  localparam logic [2:0] REG_UNUSED = 3'd7;  // no register behind this index
  localparam int DRAIN_CYCLES = 40;

  typedef struct packed {
    logic [9:0][62:0]   w;     // e2b 0..2, b2e 3..5, rate 6..8, cg velocity 9
    logic signed [31:0] down;
  } point_t;

  typedef struct packed {
    logic [5:0][31:0] val;     // force x y z, moment x y z
    logic             contact;
  } contact_t;

  logic        clk_i;
  logic        rst_ni;
  logic        start_i = 1'b0;
  logic        busy_o;
  point_t      cur = '0;
  logic        cfg_valid_i = 1'b0;
  logic        cfg_ready_o;
  logic [2:0]  cfg_index_i = '0;
  logic [31:0] cfg_data_i = '0;
  logic        done_o;
  logic signed [31:0] force_x_o, force_y_o, force_z_o;
  logic signed [31:0] moment_x_o, moment_y_o, moment_z_o;
  logic        in_contact_o;

  // Configuration mirror, updated on each register transfer
  longint k_spring = 7864320, k_damp = 0, mu_x = 52429, mu_y = 52429;
  longint off_x = 0, off_y = 0, off_z = 0;

  point_t   pending_points[$];
  contact_t expected_contacts[$];
  int       idle_pct = 16;
  int       errors = 0;
  logic     took = 1'b0;
  logic     cfg_took = 1'b0;

  gear_contact_force_unit dut (
    .clk_i, .rst_ni, .start_i, .busy_o,
    .e2b_row0_i(cur.w[0]), .e2b_row1_i(cur.w[1]), .e2b_row2_i(cur.w[2]),
    .b2e_row0_i(cur.w[3]), .b2e_row1_i(cur.w[4]), .b2e_row2_i(cur.w[5]),
    .rate_row0_i(cur.w[6]), .rate_row1_i(cur.w[7]), .rate_row2_i(cur.w[8]),
    .cg_velocity_i(cur.w[9]), .cg_down_i(cur.down),
    .cfg_valid_i, .cfg_ready_o, .cfg_index_i, .cfg_data_i,
    .done_o, .force_x_o, .force_y_o, .force_z_o,
    .moment_x_o, .moment_y_o, .moment_z_o, .in_contact_o
  );

  always begin
    clk_i = 1'b1;
    #5;
    clk_i = 1'b0;
    #5;
  end

  // ---------------- fixed-point prediction ----------------
  function automatic longint clamp32(input longint x);
    if (x > 64'sd2147483647) return 64'sd2147483647;
    if (x < -64'sd2147483648) return -64'sd2147483648;
    return x;
  endfunction

  function automatic longint lane(input logic [62:0] w, input int j);
    logic signed [20:0] e;
    e = w[21*j +: 21];
    return longint'(e);
  endfunction

  // Q8.12 row times Q16.16 vector, exact sum, floor shift, clamp
  function automatic longint row_dot(input logic [62:0] row, input longint a, input longint b,
                                     input longint c);
    longint acc;
    acc = lane(row, 0) * a + lane(row, 1) * b + lane(row, 2) * c;
    return clamp32(acc >>> 12);
  endfunction

  function automatic longint qmul(input longint a, input longint b);
    longint p;
    p = a * b;
    return p >>> 16;
  endfunction

  function automatic longint coulomb(input longint mu, input longint fz, input longint v);
    longint p;
    p = qmul(mu, fz);
    if (v > 0) return clamp32(-p);
    if (v < 0) return clamp32(p);
    return 0;
  endfunction

  function automatic contact_t contact_force(input point_t p);
    contact_t r;
    longint pe[3], pb[3], wp[3], vb[3], ve[3], fe[3], re[3];
    longint depth, fz;
    r = '0;
    for (int i = 0; i < 3; i++) pe[i] = row_dot(p.w[3+i], off_x, off_y, off_z);
    depth = clamp32(pe[2] + longint'(p.down));
    if (depth < 0) return r;
    pe[2] = 0;
    for (int i = 0; i < 3; i++) pb[i] = row_dot(p.w[i], pe[0], pe[1], pe[2]);
    for (int i = 0; i < 3; i++) wp[i] = row_dot(p.w[6+i], pb[0], pb[1], pb[2]);
    for (int i = 0; i < 3; i++) vb[i] = clamp32(wp[i] + lane(p.w[9], i) * 16);
    for (int i = 0; i < 3; i++) ve[i] = row_dot(p.w[3+i], vb[0], vb[1], vb[2]);
    fz = clamp32(qmul(k_spring, depth) + qmul(k_damp, ve[2]));
    fe[0] = coulomb(mu_x, fz, ve[0]);
    fe[1] = coulomb(mu_y, fz, ve[1]);
    fe[2] = clamp32(-fz);
    // moment = force cross (-point)
    re[0] = clamp32(qmul(fe[1], -pe[2]) - qmul(fe[2], -pe[1]));
    re[1] = clamp32(qmul(fe[2], -pe[0]) - qmul(fe[0], -pe[2]));
    re[2] = clamp32(qmul(fe[0], -pe[1]) - qmul(fe[1], -pe[0]));
    for (int i = 0; i < 3; i++) begin
      r.val[i]   = 32'(row_dot(p.w[i], fe[0], fe[1], fe[2]));
      r.val[3+i] = 32'(row_dot(p.w[i], re[0], re[1], re[2]));
    end
    r.contact = 1'b1;
    return r;
  endfunction

  // ---------------- stimulus helpers ----------------
  function automatic logic [20:0] pick_lane(input bit tame);
    logic [20:0] e;
    case ($urandom_range(0, 9))
      0: begin
        case ($urandom_range(0, 3))
          0: e = 21'h100000;
          1: e = 21'h0FFFFF;
          2: e = 21'h1FFFFF;
          default: e = '0;
        endcase
      end
      1, 2: e = tame ? 21'($urandom_range(0, 8192)) - 21'd4096 : 21'($urandom);
      default: e = tame ? 21'($urandom_range(0, 16384)) - 21'd8192 : 21'($urandom);
    endcase
    return e;
  endfunction

  function automatic logic [62:0] pick_row(input bit tame);
    return {pick_lane(tame), pick_lane(tame), pick_lane(tame)};
  endfunction

  function automatic point_t random_point();
    point_t p;
    int mode;
    mode = $urandom_range(0, 9);
    for (int i = 0; i < 10; i++) p.w[i] = pick_row(mode < 6);
    // still point: friction falls to zero on both axes
    if (mode == 9) begin
      for (int i = 6; i < 10; i++) p.w[i] = '0;
    end
    case ($urandom_range(0, 7))
      0: p.down = 32'sh7FFF_FFFF;
      1: p.down = 32'sh8000_0000;
      2: p.down = '0;
      3, 4: p.down = 32'($urandom);
      default: p.down = 32'($urandom_range(0, 32'h0008_0000)) - 32'h0004_0000;
    endcase
    return p;
  endfunction

  function automatic logic [62:0] splat(input logic [20:0] e);
    return {e, e, e};
  endfunction

  function automatic logic [31:0] tame_value();
    return 32'($urandom_range(0, 32'h0100_0000)) - 32'h0080_0000;
  endfunction

  // ---------------- driver ----------------
  always @(negedge clk_i) begin
    if (rst_ni && (!start_i || took)) begin
      if (pending_points.size() > 0 && $urandom_range(0, 99) >= idle_pct) begin
        cur     <= pending_points.pop_front();
        start_i <= 1'b1;
      end else begin
        start_i <= 1'b0;
      end
    end
  end

  // ---------------- monitor ----------------
  task automatic check_field(input string name, input logic [31:0] want,
                             input logic [31:0] got);
    if (want !== got) begin
      $display("%0t %s mismatch: expected %h actual %h", $time, name, want, got);
      errors++;
    end
  endtask

  always @(posedge clk_i) begin
    contact_t want;
    took     <= start_i && !busy_o;
    cfg_took <= cfg_valid_i && cfg_ready_o;
    // Mirror a register transfer
    if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_i)
        gcf_pkg::REG_SPRING:   k_spring <= longint'(signed'(cfg_data_i));
        gcf_pkg::REG_DAMPING:  k_damp   <= longint'(signed'(cfg_data_i));
        gcf_pkg::REG_FRIC_X:   mu_x     <= longint'(signed'(cfg_data_i));
        gcf_pkg::REG_FRIC_Y:   mu_y     <= longint'(signed'(cfg_data_i));
        gcf_pkg::REG_OFFSET_X: off_x    <= longint'(signed'(cfg_data_i));
        gcf_pkg::REG_OFFSET_Y: off_y    <= longint'(signed'(cfg_data_i));
        gcf_pkg::REG_OFFSET_Z: off_z    <= longint'(signed'(cfg_data_i));
        default: ;
      endcase
    end
    if (rst_ni && start_i && !busy_o)
      expected_contacts.insert(expected_contacts.size(), contact_force(cur));
    // Compare each result transfer with the oldest prediction
    if (rst_ni && done_o) begin
      if (expected_contacts.size() == 0) begin
        $display("%0t unexpected result: expected none actual %h", $time, force_x_o);
        errors++;
      end else begin
        want = expected_contacts.pop_front();
        check_field("force_x", want.val[0], force_x_o);
        check_field("force_y", want.val[1], force_y_o);
        check_field("force_z", want.val[2], force_z_o);
        check_field("moment_x", want.val[3], moment_x_o);
        check_field("moment_y", want.val[4], moment_y_o);
        check_field("moment_z", want.val[5], moment_z_o);
        check_field("in_contact", 32'(want.contact), 32'(in_contact_o));
      end
    end
  end

  // ---------------- sequencing ----------------
  task automatic write_reg(input logic [2:0] idx, input logic [31:0] data);
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    cfg_valid_i <= 1'b1;
    @(negedge clk_i);
    while (!cfg_took) @(negedge clk_i);
    cfg_valid_i <= 1'b0;
    @(negedge clk_i);
  endtask

  // Hold until every prediction has been met, then let the pipeline empty
  task automatic drain();
    while (pending_points.size() > 0 || start_i || expected_contacts.size() > 0)
      @(negedge clk_i);
    repeat (DRAIN_CYCLES) @(negedge clk_i);
  endtask

  task automatic write_all(input logic [31:0] v[7]);
    write_reg(gcf_pkg::REG_SPRING, v[0]);
    write_reg(gcf_pkg::REG_DAMPING, v[1]);
    write_reg(gcf_pkg::REG_FRIC_X, v[2]);
    write_reg(gcf_pkg::REG_FRIC_Y, v[3]);
    write_reg(gcf_pkg::REG_OFFSET_X, v[4]);
    write_reg(gcf_pkg::REG_OFFSET_Y, v[5]);
    write_reg(gcf_pkg::REG_OFFSET_Z, v[6]);
    write_reg(REG_UNUSED, 32'($urandom));
  endtask

  initial begin
    point_t p;
    logic [31:0] v[7];
    rst_ni = 1'b0;
    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Directed points under the reset configuration
    p = '0;
    pending_points.insert(pending_points.size(), p);   // exactly on ground, still
    p.down = -32'sd1;
    pending_points.insert(pending_points.size(), p);   // just above ground
    p.down = 32'sh7FFF_FFFF;
    pending_points.insert(pending_points.size(), p);
    p.down = 32'sh8000_0000;
    pending_points.insert(pending_points.size(), p);
    for (int i = 0; i < 10; i++) p.w[i] = splat(21'h0FFFFF);
    p.down = 32'sh7FFF_FFFF;
    pending_points.insert(pending_points.size(), p);
    for (int i = 0; i < 10; i++) p.w[i] = splat(21'h100000);
    pending_points.insert(pending_points.size(), p);
    for (int i = 0; i < 10; i++) p.w[i] = {63{1'b1}};
    p.down = 32'sd65536;
    pending_points.insert(pending_points.size(), p);
    // identity attitude, moving forward, then with negative y and z velocity
    for (int s = 0; s < 4; s++) begin
      p = '0;
      p.w[0] = 63'd4096; p.w[3] = 63'd4096;
      p.w[1] = 63'd4096 << 21; p.w[4] = 63'd4096 << 21;
      p.w[2] = 63'd4096 << 42; p.w[5] = 63'd4096 << 42;
      p.w[9] = (s[0] ? {21'h1FF000, 21'h1FF000, 21'd0} : {21'd2048, 21'd4096, 21'd8192});
      p.down = s[1] ? 32'sd131072 : 32'sd0;
      pending_points.insert(pending_points.size(), p);
    end
    drain();

    for (int phase = 0; phase < 6; phase++) begin
      idle_pct = (phase < 2) ? 16 : (phase < 4) ? 71 : 0;
      case (phase)
        1: foreach (v[i]) v[i] = tame_value();
        2: foreach (v[i]) v[i] = 32'h7FFF_FFFF;
        3: foreach (v[i]) v[i] = 32'h8000_0000;
        4: foreach (v[i]) v[i] = 32'($urandom);
        5: foreach (v[i]) v[i] = tame_value();
        default: ;
      endcase
      if (phase > 0) write_all(v);
      repeat (255) pending_points.insert(pending_points.size(), random_point());
      drain();
    end

    if (errors == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

  // Run limit
  initial begin
    #5ms;
    $display("FAIL");
    $finish;
  end

endmodule
